### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types for the double-ended queue: request codes and result status.
// ----------------------------------------------------------------------------
package deq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} deq_op_t;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 5;

	// Status of one request, produced by the pointer logic
	typedef struct packed {
		logic rejected;
		logic is_empty;
		logic is_full;
	} deq_status_t;

endpackage

### hdl/deq_mem.sv
// ----------------------------------------------------------------------------
// deq_mem
// Slot storage: one write port and two registered read ports, write-first.
// ----------------------------------------------------------------------------
module deq_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [deq_pkg::WORD_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr_front,
	input  logic [AW-1:0]             raddr_back,
	output logic [deq_pkg::WORD_W-1:0] rdata_front,
	output logic [deq_pkg::WORD_W-1:0] rdata_back
);
	import deq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Forward the word written in the same cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_front <= (we && waddr == raddr_front) ? wdata : mem[raddr_front];
			rdata_back  <= (we && waddr == raddr_back) ? wdata : mem[raddr_back];
		end
	end

endmodule

### hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer and occupancy; turns a request into slot write and reads.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned CW    = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  deq_pkg::deq_op_t           op,
	input  logic [deq_pkg::WORD_W-1:0] value,
	output logic                       we,
	output logic [AW-1:0]              waddr,
	output logic [deq_pkg::WORD_W-1:0] wdata,
	output logic [AW-1:0]              raddr_front,
	output logic [AW-1:0]              raddr_back,
	output logic [CW-1:0]              occ_next,
	output deq_pkg::deq_status_t       status
);
	import deq_pkg::*;

	localparam int unsigned SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	logic [AW-1:0] head_q, head_next;
	logic [CW-1:0] occ_q;
	logic          is_full_now, is_empty_now;
	logic [SW-1:0] tail_sum, back_sum;
	logic          rej;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= DEPTH_S) ? s - DEPTH_S : s;
		return r[AW-1:0];
	endfunction

	assign is_full_now  = (occ_q == CW'(DEPTH));
	assign is_empty_now = (occ_q == '0);
	assign tail_sum     = SW'(head_q) + SW'(occ_q);

	always_comb begin
		head_next = head_q;
		occ_next  = occ_q;
		we        = 1'b0;
		waddr     = head_q;
		rej       = 1'b0;
		case (op)
			OP_PUSH_FRONT: begin
				if (is_full_now) begin
					rej = 1'b1;
				end else begin
					head_next = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
					waddr     = head_next;
					we        = accept;
					occ_next  = occ_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full_now) begin
					rej = 1'b1;
				end else begin
					waddr    = wrap(tail_sum);
					we       = accept;
					occ_next = occ_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty_now) begin
					rej = 1'b1;
				end else begin
					head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					occ_next  = occ_q - 1'b1;
				end
			end
			default: begin
				if (is_empty_now) begin
					rej = 1'b1;
				end else begin
					occ_next = occ_q - 1'b1;
				end
			end
		endcase
	end

	assign wdata = value;

	// Back entry sits at head + count - 1 after the request
	assign back_sum    = (occ_next == '0) ? SW'(head_next)
	                                      : SW'(head_next) + SW'(occ_next) - 1'b1;
	assign raddr_front = head_next;
	assign raddr_back  = wrap(back_sum);

	assign status = '{rejected: rej,
	                  is_empty: (occ_next == '0),
	                  is_full:  (occ_next == CW'(DEPTH))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (accept) begin
			head_q <= head_next;
			occ_q  <= occ_next;
		end
	end

endmodule

### hdl/double_ended_queue.sv
// An accepted request passes the read stage, then the output register, before m_tvalid rises.
// Throughput: one request per cycle while m_tready is high; one write and two reads per cycle.
// A stalled output holds one result in the output register and one in the read stage.
// Reset (arst_n low, asynchronous) empties the deque: head and count go to zero.
// Slot contents are not cleared; an empty deque reports zero for both ends.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 32-bit words in a ring of DEPTH slots with head and count.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] front_value, [63:32] back_value, [68:64] entry_count,
	// [69] is_empty, [70] is_full, [71] rejected
	output logic [71:0] m_tdata
);
	import deq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;

	logic              accept;
	logic              we;
	logic [AW-1:0]     waddr, raddr_front, raddr_back;
	logic [WORD_W-1:0] wdata, rdata_front, rdata_back;
	logic [CW-1:0]     occ_next;
	deq_status_t       status;

	// Read stage: memory read data plus the status of the same request
	logic              valid_s1;
	deq_status_t       status_s1;
	logic [CW-1:0]     count_s1;
	logic              s1_adv;
	logic [EW-1:0]     count_ext;

	// Output register
	logic              out_valid_q;
	logic [71:0]       out_data_q;

	// Take a request when the read stage is free or is moving on
	assign s1_adv   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	deq_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (deq_op_t'(s_tuser)),
		.value      (s_tdata),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.raddr_front(raddr_front),
		.raddr_back (raddr_back),
		.occ_next   (occ_next),
		.status     (status)
	);

	// Read ports fire only on accept, so read data holds while stalled
	deq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk        (clk),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.re         (accept),
		.raddr_front(raddr_front),
		.raddr_back (raddr_back),
		.rdata_front(rdata_front),
		.rdata_back (rdata_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			count_s1  <= occ_next;
		end
	end

	// Count field carries the low bits of the occupancy
	assign count_ext = EW'(count_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Zero both ends when the deque is empty
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {status_s1.rejected, status_s1.is_full, status_s1.is_empty,
			               count_ext[COUNT_W-1:0],
			               status_s1.is_empty ? '0 : rdata_back,
			               status_s1.is_empty ? '0 : rdata_front};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach the read stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(status_s1) && $stable(count_s1))
		else $error("stalled read stage changed");

	a_empty_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(status_s1.is_empty && status_s1.is_full))
		else $error("deque reported empty and full at once");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q && $past(!valid_s1) |-> !$past(s1_adv))
		else $error("output loaded without a pending result");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop requests at both ends of double_ended_queue and checks
// every result against a ring-buffer predictor kept inside this module.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int unsigned DEPTH = 16;

	// Result word as it leaves the block, lowest field last in this list
	typedef struct packed {
		logic               rejected;
		logic               is_full;
		logic               is_empty;
		logic [COUNT_W-1:0] entry_count;
		logic [WORD_W-1:0]  back_value;
		logic [WORD_W-1:0]  front_value;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [1:0]  s_tuser = '0;   // [1:0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [31:0] front_value, [63:32] back_value, [68:64] entry_count,
	// [69] is_empty, [70] is_full, [71] rejected
	logic [71:0] m_tdata;

	// Predictor state: a private copy of the ring, its head and its fill level
	logic [WORD_W-1:0] ring [DEPTH];
	int unsigned       ring_head = 0;
	int unsigned       ring_fill = 0;

	deque_result_t pending_results[$];
	int unsigned   mismatch_count = 0;

	// Idling knobs; cleared for the back-to-back stretch
	bit send_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int unsigned stall_left = 0;

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Random word, with the extremes of the signed range mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Apply one request to the predictor ring and return what the block must report.
	// Full pushes and empty pops leave the ring alone and raise rejected.
	function automatic deque_result_t apply_request(deq_op_t op, logic [WORD_W-1:0] word);
		deque_result_t r;
		r = '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (ring_fill >= DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					// new word goes ahead of the old first entry
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring[ring_head] = word;
					ring_fill++;
				end
			end
			OP_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					ring[(ring_head + ring_fill) % DEPTH] = word;
					ring_fill++;
				end
			end
			OP_POP_FRONT: begin
				if (ring_fill == 0) begin
					r.rejected = 1'b1;
				end else begin
					ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end
			end
			default: begin
				// back pop: the entry before the last becomes the new last
				if (ring_fill == 0) begin
					r.rejected = 1'b1;
				end else begin
					ring_fill--;
				end
			end
		endcase
		// an empty deque reports zero at both ends
		if (ring_fill != 0) begin
			r.front_value = ring[ring_head];
			r.back_value  = ring[(ring_head + ring_fill - 1) % DEPTH];
		end
		r.entry_count = ring_fill[COUNT_W-1:0];
		r.is_empty    = (ring_fill == 0);
		r.is_full     = (ring_fill >= DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 60) begin
			$display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Send one request. Valid stays high from the previous request when no gap
	// is drawn, so it is never lowered and raised in the same step.
	task automatic send_request(input deq_op_t op, input logic [31:0] word);
		int unsigned gap;
		logic ready_seen;
		gap = send_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		// sample ready mid-cycle, where it has settled for the coming edge
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		pending_results.push_back(apply_request(op, word));
	endtask

	// Receiver: hold ready high, drop it for stalls of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result that will transfer at the coming edge with the
	// oldest prediction, field by field.
	always @(negedge clk) begin : check_results
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", '0, m_tdata[31:0]);
			end else begin
				want = pending_results.pop_front();
				if (got.front_value !== want.front_value)
					report_mismatch("front_value", want.front_value, got.front_value);
				if (got.back_value !== want.back_value)
					report_mismatch("back_value", want.back_value, got.back_value);
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", want.entry_count, got.entry_count);
				if (got.is_empty !== want.is_empty)
					report_mismatch("is_empty", want.is_empty, got.is_empty);
				if (got.is_full !== want.is_full)
					report_mismatch("is_full", want.is_full, got.is_full);
				if (got.rejected !== want.rejected)
					report_mismatch("rejected", want.rejected, got.rejected);
			end
		end
	end

	// Empty pops at both ends, extremes at both ends, then fill to the brim
	// and push once more at each end to see the full rejection.
	task automatic test_directed_edges();
		int unsigned i;
		send_request(OP_POP_FRONT, 32'h1234_5678);
		send_request(OP_POP_BACK, 32'hdead_beef);
		send_request(OP_PUSH_FRONT, 32'h8000_0000);
		send_request(OP_PUSH_BACK, 32'h7fff_ffff);
		send_request(OP_POP_BACK, 32'h0);
		send_request(OP_POP_FRONT, 32'h0);
		// front pushes put each word ahead of the previous one
		for (i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0: send_request(OP_PUSH_FRONT, 32'hffff_ffff - i);
				1: send_request(OP_PUSH_BACK, 32'h8000_0000 + i);
				2: send_request(OP_PUSH_FRONT, 32'h7fff_ffff - i);
				default: send_request(OP_PUSH_BACK, i);
			endcase
		end
		send_request(OP_PUSH_FRONT, 32'h5555_5555);
		send_request(OP_PUSH_BACK, 32'haaaa_aaaa);
	endtask

	// Uniform mix of the four operations
	task automatic test_random_mix(input int unsigned n_items);
		repeat (n_items) send_request(deq_op_t'($urandom_range(0, 3)), pick_word());
	endtask

	// Swing between filling and draining so both ends of the range get visited
	// often, with rejected pushes at the top and rejected pops at the bottom.
	task automatic test_fill_drain(input int unsigned n_items);
		bit filling;
		bit pick_push;
		filling = 1'b1;
		repeat (n_items) begin
			pick_push = filling ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
			if (pick_push)
				send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
			else
				send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_word());
			if (ring_fill >= DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (ring_fill == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
		end
	endtask

	// Back-to-back requests with the receiver always ready
	task automatic test_streaming(input int unsigned n_items);
		send_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_fill_drain(n_items);
		send_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_random_mix(450);
		test_fill_drain(600);
		test_streaming(300);

		// drop valid, then drain the pipeline
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hang guard: far beyond the slowest correct run
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hdl/deq_pkg.sv
hdl/deq_mem.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue.sv
test/testbench.sv
